>>> design/ghp_pkg.sv
`default_nettype none

package ghp_pkg;

  // Command codes
  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_LOOKUP  = 2'd2,
    CMD_REPORT  = 2'd3
  } cmd_e;

  // Result codes
  typedef enum logic [1:0] {
    RC_OK       = 2'd0,
    RC_EMPTY    = 2'd1,
    RC_INVALID  = 2'd2,
    RC_OVERFLOW = 2'd3
  } rc_e;

  // Slot state codes
  localparam logic [2:0] ST_NONE        = 3'd0;
  localparam logic [2:0] ST_PENDING     = 3'd1;
  localparam logic [2:0] ST_DOWNLOADING = 3'd2;

  // Input word
  typedef struct packed {
    cmd_e        command;
    logic [31:0] handle;
    logic [15:0] slot_number;
    logic [2:0]  new_state;
    logic [15:0] new_status;
  } in_word_t;

  // Result word
  typedef struct packed {
    rc_e         result_code;
    logic [31:0] handle_out;
    logic [15:0] slot_out;
    logic [2:0]  state_out;
    logic [15:0] status_out;
    logic        cancel_request;
  } out_word_t;

  // One slot table entry
  typedef struct packed {
    logic [15:0] gen;
    logic [2:0]  state;
    logic [15:0] status;
  } slot_ent_t;

  // Slot table write request
  typedef struct packed {
    logic      en;
    slot_ent_t ent;
  } slot_wr_t;

  // Free stack operation
  typedef struct packed {
    logic        pop;
    logic        push;
    logic [15:0] idx;
  } stk_op_t;

  // Generation bump, zero is skipped
  function automatic logic [15:0] next_gen(input logic [15:0] g);
    logic [15:0] n;
    n = g + 16'd1;
    return (n == 16'd0) ? 16'd1 : n;
  endfunction

endpackage

`default_nettype wire

>>> design/ghp_ram.sv
`default_nettype none

module ghp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] q_r;

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      q_r <= mem_r[raddr];
    end
  end

  assign rdata = q_r;

endmodule

`default_nettype wire

>>> design/ghp_free_stack.sv
`default_nettype none

module ghp_free_stack
  import ghp_pkg::*;
#(
  parameter int POOL_SLOTS = 16,
  localparam int SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1,
  localparam int TW = $clog2(POOL_SLOTS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          clr_busy,
  input  wire logic [SW-1:0] clr_addr,
  input  wire stk_op_t       op,
  output logic      [TW-1:0] top,
  output logic      [15:0]   tos,
  output logic      [15:0]   tos_nxt
);

  logic [TW-1:0] top_r, top_nxt;
  logic [15:0]   tos_r;
  logic          byp_r, byp_nxt;
  logic [15:0]   byp_val_r, byp_val_nxt;
  logic [15:0]   second;
  logic          we;
  logic [SW-1:0] waddr;
  logic [15:0]   wdata;
  logic [TW:0]   rd_pos;
  logic [15:0]   rd_data;

  // Entry below the cached top: forwarded right after a push
  assign second = byp_r ? byp_val_r : rd_data;

  always_comb begin
    top_nxt     = top_r;
    tos_nxt     = tos_r;
    byp_nxt     = byp_r;
    byp_val_nxt = byp_val_r;
    we          = 1'b0;
    waddr       = clr_addr;
    wdata       = 16'(POOL_SLOTS) - 16'(clr_addr);
    if (clr_busy) begin
      we = 1'b1;
    end else if (op.pop) begin
      top_nxt = top_r - TW'(1);
      tos_nxt = second;
      byp_nxt = 1'b0;
    end else if (op.push) begin
      top_nxt     = top_r + TW'(1);
      tos_nxt     = op.idx;
      byp_nxt     = 1'b1;
      byp_val_nxt = tos_r;
      // old top drops into the memory
      if (top_r != '0) begin
        we    = 1'b1;
        waddr = SW'(top_r - TW'(1));
        wdata = tos_r;
      end
    end
  end

  // Keep the read pointed at the entry below the next top
  assign rd_pos = (TW+1)'(top_nxt) - (TW+1)'(2);

  ghp_ram #(
    .WIDTH (16),
    .DEPTH (POOL_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (1'b1),
    .raddr (SW'(rd_pos)),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r     <= TW'(POOL_SLOTS);
      tos_r     <= 16'd1;
      byp_r     <= 1'b1;
      byp_val_r <= 16'd2;
    end else begin
      top_r     <= top_nxt;
      tos_r     <= tos_nxt;
      byp_r     <= byp_nxt;
      byp_val_r <= byp_val_nxt;
    end
  end

  assign top = top_r;
  assign tos = tos_r;

endmodule

`default_nettype wire

>>> design/ghp_slot_table.sv
`default_nettype none

module ghp_slot_table
  import ghp_pkg::*;
#(
  parameter int POOL_SLOTS = 16,
  localparam int SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          clr_busy,
  input  wire logic [SW-1:0] clr_addr,
  input  wire logic          rd_en,
  input  wire logic [SW-1:0] rd_addr,
  input  wire slot_wr_t      wr,
  input  wire logic [SW-1:0] wr_addr,
  output slot_ent_t          rd_ent
);

  logic          byp_r, byp_nxt;
  slot_ent_t     byp_val_r, byp_val_nxt;
  logic          we;
  logic [SW-1:0] waddr;
  slot_ent_t     wdata;
  slot_ent_t     q;

  // Clearing pass has priority over the exec write
  always_comb begin
    we    = clr_busy | wr.en;
    waddr = clr_busy ? clr_addr : wr_addr;
    wdata = clr_busy ? '0 : wr.ent;
  end

  // Same-edge write to the address being read is forwarded
  always_comb begin
    byp_nxt     = byp_r;
    byp_val_nxt = byp_val_r;
    if (rd_en) begin
      byp_nxt     = wr.en && (wr_addr == rd_addr);
      byp_val_nxt = wr.ent;
    end
  end

  ghp_ram #(
    .WIDTH ($bits(slot_ent_t)),
    .DEPTH (POOL_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= byp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byp_val_r <= byp_val_nxt;
  end

  assign rd_ent = byp_r ? byp_val_r : q;

endmodule

`default_nettype wire

>>> design/generational_handle_pool_core.sv
`default_nettype none

// Channel   Ports                          Word
// --------  -----------------------------  ----------
// command   in_valid / in_ready / in_data   in_word_t
// result    out_valid / out_ready / out_data out_word_t
//
// One command per cycle while no clearing pass runs and the result is not stalled.
// Slot table read at the accept edge, then execute into the result register.
// After reset a clearing pass over all POOL_SLOTS entries fills the free stack and
// zeroes the slot table; in_ready stays low during it.
// A stalled result holds the execute stage; a new command is still taken while
// the execute stage is empty.

module generational_handle_pool_core
  import ghp_pkg::*;
#(
  parameter int POOL_SLOTS = 16,
  localparam int SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1,
  localparam int TW = $clog2(POOL_SLOTS + 1)
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  logic          clr_busy_r;
  logic [SW-1:0] clr_cnt_r;
  logic          s1_valid_r;
  in_word_t      s1_word_r;
  logic          out_valid_r;
  out_word_t     out_data_r;
  logic          s1_fire;
  logic          acc;
  logic [SW-1:0] rd_addr;
  slot_ent_t     ent;
  slot_wr_t      wr;
  logic [SW-1:0] wr_addr;
  stk_op_t       op;
  logic [TW-1:0] top;
  logic [15:0]   tos;
  logic [15:0]   tos_nxt;
  out_word_t     res;
  logic [15:0]   idx;
  logic          in_range;
  logic          gen_ok;
  logic [15:0]   gen_bump;

  // Handshake
  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !clr_busy_r && (!s1_valid_r || s1_fire);
  assign acc      = in_valid && in_ready;

  // Slot table read address for the incoming word
  always_comb begin
    case (in_data.command)
      CMD_ALLOC:  rd_addr = SW'(tos_nxt - 16'd1);
      CMD_REPORT: rd_addr = SW'(in_data.slot_number - 16'd1);
      default:    rd_addr = SW'(in_data.handle[15:0] - 16'd1);
    endcase
  end

  ghp_slot_table #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_slots (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr_busy (clr_busy_r),
    .clr_addr (clr_cnt_r),
    .rd_en    (acc),
    .rd_addr  (rd_addr),
    .wr       (wr),
    .wr_addr  (wr_addr),
    .rd_ent   (ent)
  );

  ghp_free_stack #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr_busy (clr_busy_r),
    .clr_addr (clr_cnt_r),
    .op       (op),
    .top      (top),
    .tos      (tos),
    .tos_nxt  (tos_nxt)
  );

  // Execute stage
  always_comb begin
    case (s1_word_r.command)
      CMD_ALLOC:  idx = tos;
      CMD_REPORT: idx = s1_word_r.slot_number;
      default:    idx = s1_word_r.handle[15:0];
    endcase
    in_range = (idx != 16'd0) && ({1'b0, idx} <= 17'(POOL_SLOTS));
    gen_ok   = ent.gen == s1_word_r.handle[31:16];
    gen_bump = next_gen(ent.gen);

    res        = '0;
    res.result_code = RC_OK;
    wr.en      = 1'b0;
    wr.ent     = ent;
    wr_addr    = SW'(idx - 16'd1);
    op.pop     = 1'b0;
    op.push    = 1'b0;
    op.idx     = idx;

    case (s1_word_r.command)
      CMD_ALLOC: begin
        if (top == '0) begin
          res.result_code = RC_EMPTY;
        end else begin
          wr.en          = s1_fire;
          wr.ent.gen     = gen_bump;
          wr.ent.state   = ST_PENDING;
          wr.ent.status  = 16'd0;
          op.pop         = s1_fire;
          res.handle_out = {gen_bump, idx};
          res.slot_out   = idx;
        end
      end
      CMD_RELEASE: begin
        if (!(in_range && gen_ok)) begin
          res.result_code = RC_INVALID;
        end else begin
          res.cancel_request = (ent.state == ST_PENDING) ||
                               (ent.state == ST_DOWNLOADING);
          wr.en         = s1_fire;
          wr.ent.gen    = gen_bump;
          wr.ent.state  = ST_NONE;
          wr.ent.status = 16'd0;
          res.slot_out  = idx;
          if (top == TW'(POOL_SLOTS)) begin
            res.result_code = RC_OVERFLOW;
          end else begin
            op.push = s1_fire;
          end
        end
      end
      CMD_LOOKUP: begin
        if (!(in_range && gen_ok)) begin
          res.result_code = RC_INVALID;
        end else begin
          res.state_out  = ent.state;
          res.status_out = ent.status;
        end
      end
      default: begin
        if (!in_range) begin
          res.result_code = RC_INVALID;
        end else begin
          wr.en         = s1_fire;
          wr.ent.state  = s1_word_r.new_state;
          wr.ent.status = s1_word_r.new_status;
          res.slot_out  = idx;
        end
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + SW'(1);
        if (clr_cnt_r == SW'(POOL_SLOTS - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_word_r <= in_data;
    end
    if (s1_fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
